/* rtl/wsa_pkg.sv */
// wsa_pkg: shared widths, defaults and codes of the weighted score accumulator
// no dependencies; used by the interfaces, the core and its checker
`default_nettype none

package wsa_pkg;

  localparam int CMD_W  = 3;
  localparam int ROW_W  = 3;
  localparam int COL_W  = 10;
  localparam int OPND_W = 32;
  localparam int SUM_W  = 48;

  localparam int CFG_TRAITS_W  = 4;
  localparam int CFG_MARKERS_W = 11;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 11;

  localparam int FRAC_BITS = 16;

  localparam int DEF_MAX_TRAITS  = 8;
  localparam int DEF_MAX_MARKERS = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_WEIGHT   = 3'd0,
    CMD_LOAD_RESIDUAL = 3'd1,
    CMD_FINISH_SAMPLE = 3'd2,
    CMD_ADD_GENOTYPE  = 3'd3,
    CMD_CLEAR         = 3'd4,
    CMD_READ          = 3'd5
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TRAITS  = 1'd0,
    REG_MARKERS = 1'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/wsa_if.sv */
// wsa_req_if and wsa_res_if: valid/ready channels of the accumulator
// depends on wsa_pkg for field widths
`default_nettype none

interface wsa_req_if import wsa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [ROW_W-1:0]         row_index;
  logic [COL_W-1:0]         column_index;
  logic signed [OPND_W-1:0] operand_value;

  modport source (output valid, command, row_index, column_index, operand_value,
                  input ready);
  modport sink (input valid, command, row_index, column_index, operand_value,
                output ready);
endinterface

interface wsa_res_if import wsa_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] sum_value;
  logic                    saturated;

  modport source (output valid, sum_value, saturated, input ready);
  modport sink (input valid, sum_value, saturated, output ready);
endinterface

`default_nettype wire

/* rtl/wsa_ram.sv */
// wsa_ram: generic single-write, single-read synchronous RAM, registered read
// no dependencies
`default_nettype none

module wsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/weighted_score_accumulator_core.sv */
// Weighted score accumulator: builds a trait-by-marker score matrix as a sum of
// outer products. Weights, residuals and scores live in synchronous RAMs; one
// shared signed multiplier serves both the projection and the accumulation.
// Loading a weight or a residual does not hold the request channel. Finishing a
// sample forms k*k weight-residual products, one per cycle through the shared
// multiplier (k = traits in use). Adding a genotype does one read-modify-write
// of a score entry per cycle, one for each trait in use; a marker out of range
// is dropped without leaving idle. A read waits for the result slot to be free.
// After reset and after a clear, a clearing pass writes zero to all score entries,
// MAX_TRAITS rounded up to a power of two times MAX_MARKERS rounded up
// (8192 entries at the defaults), during which no item is accepted;
// configuration writes are taken at any time.
// depends on wsa_pkg, wsa_if.sv and wsa_ram
`default_nettype none

module weighted_score_accumulator_core
  import wsa_pkg::*;
#(
  parameter int MAX_TRAITS  = DEF_MAX_TRAITS,
  parameter int MAX_MARKERS = DEF_MAX_MARKERS,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   config_write,
  input  logic [CFG_INDEX_W-1:0] config_index,
  input  logic [CFG_DATA_W-1:0]  config_data,
  wsa_req_if.sink                request,
  wsa_res_if.source              result
);

  localparam int TAW    = (MAX_TRAITS > 1) ? $clog2(MAX_TRAITS) : 1;
  localparam int MAW    = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int WAW    = 2 * TAW;
  localparam int SAW    = TAW + MAW;
  localparam int KW     = ($clog2(MAX_TRAITS + 1) > CFG_TRAITS_W) ?
                          $clog2(MAX_TRAITS + 1) : CFG_TRAITS_W;
  localparam int PW     = ($clog2(MAX_MARKERS + 1) > CFG_MARKERS_W) ?
                          $clog2(MAX_MARKERS + 1) : CFG_MARKERS_W;
  localparam int PROD_W = 2 * VALUE_WIDTH;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int PS_W   = SH_W + TAW + 1;
  localparam int ACC_W  = SUM_W + 1;

  localparam logic signed [PS_W-1:0] PMAX = {{(PS_W-VALUE_WIDTH+1){1'b0}},
                                             {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [PS_W-1:0] PMIN = {{(PS_W-VALUE_WIDTH+1){1'b1}},
                                             {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [SUM_W-1:0] AMAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] AMIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PROJ  = 6'b000100,
    S_GENO  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_READ  = 6'b100000
  } state_t;

  state_t state;

  logic [CFG_TRAITS_W-1:0]  traits_in_use;
  logic [CFG_MARKERS_W-1:0] markers_in_use;
  logic [KW-1:0]            k_eff;
  logic [PW-1:0]            p_eff;

  logic                          accept;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic                          in_rd_ok;
  logic                          in_geno_ok;

  logic                          mode_geno;
  logic [MAW-1:0]                col_m;
  logic signed [VALUE_WIDTH-1:0] val_q;
  logic                          rd_ok;

  logic [TAW-1:0] t_cnt;
  logic [TAW-1:0] j_cnt;
  logic           t_last;
  logic           j_last;
  logic [SAW-1:0] clr_cnt;

  logic                          v1;
  logic [TAW-1:0]                t1;
  logic [TAW-1:0]                j1;
  logic                          first1;
  logic                          last1;
  logic signed [VALUE_WIDTH-1:0] a1;

  logic                          v2;
  logic [TAW-1:0]                t2;
  logic [TAW-1:0]                j2;
  logic                          first2;
  logic                          last2;
  logic signed [PROD_W-1:0]      prod;

  logic signed [VALUE_WIDTH-1:0] proj [MAX_TRAITS];
  logic signed [PS_W-1:0]        pacc;
  logic signed [PS_W-1:0]        pbase;
  logic signed [PS_W-1:0]        proj_sum;
  logic signed [VALUE_WIDTH-1:0] proj_val;
  logic signed [SH_W-1:0]        sh;
  logic signed [VALUE_WIDTH-1:0] mul_a;
  logic signed [VALUE_WIDTH-1:0] mul_b;

  logic signed [SUM_W-1:0] score_old;
  logic signed [ACC_W-1:0] acc_sum;
  logic [SUM_W-1:0]        acc_val;
  logic                    acc_ovf;
  logic                    sat_flag;

  logic                   w_we;
  logic [WAW-1:0]         w_waddr;
  logic [VALUE_WIDTH-1:0] w_rdata;
  logic                   r_we;
  logic [TAW-1:0]         r_waddr;
  logic [VALUE_WIDTH-1:0] r_rdata;
  logic                   s_we;
  logic [SAW-1:0]         s_waddr;
  logic [SUM_W-1:0]       s_wdata;
  logic                   s_re;
  logic [SAW-1:0]         s_raddr;
  logic [SUM_W-1:0]       s_rdata;

  logic                    out_valid;
  logic [SUM_W-1:0]        out_sum;
  logic                    out_sat;
  logic                    slot_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      traits_in_use  <= CFG_TRAITS_W'(1);
      markers_in_use <= CFG_MARKERS_W'(1);
    end else if (config_write) begin
      case (config_index)
        REG_TRAITS:  traits_in_use  <= config_data[CFG_TRAITS_W-1:0];
        REG_MARKERS: markers_in_use <= config_data[CFG_MARKERS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (traits_in_use == '0) begin
      k_eff = KW'(1);
    end else if (KW'(traits_in_use) > KW'(MAX_TRAITS)) begin
      k_eff = KW'(MAX_TRAITS);
    end else begin
      k_eff = KW'(traits_in_use);
    end
    if (markers_in_use == '0) begin
      p_eff = PW'(1);
    end else if (PW'(markers_in_use) > PW'(MAX_MARKERS)) begin
      p_eff = PW'(MAX_MARKERS);
    end else begin
      p_eff = PW'(markers_in_use);
    end
  end

  // request side
  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign in_val        = request.operand_value[VALUE_WIDTH-1:0];
  assign in_rd_ok      = (KW'(request.row_index) < k_eff) &&
                         (PW'(request.column_index) < p_eff);
  assign in_geno_ok    = (PW'(request.column_index) < p_eff);

  assign w_we    = accept && (request.command == CMD_LOAD_WEIGHT) &&
                   (int'(request.row_index) < MAX_TRAITS) &&
                   (int'(request.column_index) < MAX_TRAITS);
  assign w_waddr = {TAW'(request.row_index), TAW'(request.column_index)};
  assign r_we    = accept && (request.command == CMD_LOAD_RESIDUAL) &&
                   (int'(request.column_index) < MAX_TRAITS);
  assign r_waddr = TAW'(request.column_index);

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_geno <= (request.command == CMD_ADD_GENOTYPE);
      col_m     <= MAW'(request.column_index);
      val_q     <= in_val;
      rd_ok     <= in_rd_ok;
    end
  end

  // sequencer
  assign t_last    = (KW'(t_cnt) == k_eff - KW'(1));
  assign j_last    = (KW'(j_cnt) == k_eff - KW'(1));
  assign slot_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      t_cnt   <= '0;
      j_cnt   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SAW'(1);
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          t_cnt <= '0;
          j_cnt <= '0;
          if (accept) begin
            case (request.command)
              CMD_FINISH_SAMPLE: state <= S_PROJ;
              CMD_ADD_GENOTYPE: begin
                if (in_geno_ok) begin
                  state <= S_GENO;
                end
              end
              CMD_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLEAR;
              end
              CMD_READ: state <= S_READ;
              default: ;
            endcase
          end
        end
        S_PROJ: begin
          if (t_last) begin
            t_cnt <= '0;
            j_cnt <= j_cnt + TAW'(1);
            if (j_last) begin
              state <= S_DRAIN;
            end
          end else begin
            t_cnt <= t_cnt + TAW'(1);
          end
        end
        S_GENO: begin
          t_cnt <= t_cnt + TAW'(1);
          if (t_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stage 1: operands from memory
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= (state == S_PROJ) || (state == S_GENO);
    end
  end

  always_ff @(posedge clk) begin
    t1     <= t_cnt;
    j1     <= j_cnt;
    first1 <= (t_cnt == '0);
    last1  <= t_last;
    a1     <= proj[t_cnt];
  end

  // stage 2: shared multiplier
  assign mul_a = mode_geno ? a1 : r_rdata;
  assign mul_b = mode_geno ? val_q : w_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    t2     <= t1;
    j2     <= j1;
    first2 <= first1;
    last2  <= last1;
    prod   <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // stage 3: projection sum or score update
  assign sh        = prod[PROD_W-1:FRAC_BITS];
  assign score_old = s_rdata;

  always_comb begin
    if (first2) begin
      pbase = '0;
    end else begin
      pbase = pacc;
    end
    proj_sum = pbase + PS_W'(sh);
    if (proj_sum > PMAX) begin
      proj_val = VALUE_WIDTH'(PMAX);
    end else if (proj_sum < PMIN) begin
      proj_val = VALUE_WIDTH'(PMIN);
    end else begin
      proj_val = VALUE_WIDTH'(proj_sum);
    end

    acc_sum = ACC_W'(score_old) + ACC_W'(sh);
    case (acc_sum[ACC_W-1:ACC_W-2])
      2'b01: begin
        acc_val = AMAX;
        acc_ovf = 1'b1;
      end
      2'b10: begin
        acc_val = AMIN;
        acc_ovf = 1'b1;
      end
      default: begin
        acc_val = acc_sum[SUM_W-1:0];
        acc_ovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v2 && !mode_geno) begin
      pacc <= proj_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TRAITS; i++) begin
        proj[i] <= '0;
      end
    end else if (v2 && !mode_geno && last2) begin
      proj[j2] <= proj_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
    end else if (accept && (request.command == CMD_CLEAR)) begin
      sat_flag <= 1'b0;
    end else if (v2 && mode_geno && acc_ovf) begin
      sat_flag <= 1'b1;
    end
  end

  // score memory ports
  assign s_we    = (state == S_CLEAR) || (v2 && mode_geno);
  assign s_waddr = (state == S_CLEAR) ? clr_cnt : {t2, col_m};
  assign s_wdata = (state == S_CLEAR) ? '0 : acc_val;
  assign s_re    = (accept && (request.command == CMD_READ) && in_rd_ok) ||
                   (v1 && mode_geno);
  assign s_raddr = (state == S_IDLE) ?
                   {TAW'(request.row_index), MAW'(request.column_index)} :
                   {t1, col_m};

  wsa_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (1 << WAW)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_val),
    .re    (state == S_PROJ),
    .raddr ({t_cnt, j_cnt}),
    .rdata (w_rdata)
  );

  wsa_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (1 << TAW)
  ) u_residual_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (in_val),
    .re    (state == S_PROJ),
    .raddr (t_cnt),
    .rdata (r_rdata)
  );

  wsa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (1 << SAW)
  ) u_score_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_READ) && slot_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_READ) && slot_free) begin
      out_sum <= rd_ok ? s_rdata : '0;
      out_sat <= sat_flag;
    end
  end

  assign result.valid     = out_valid;
  assign result.sum_value = out_sum;
  assign result.saturated = out_sat;

endmodule

`default_nettype wire

/* rtl/wsa_checker.sv */
// wsa_checker: port-level assertions for the weighted score accumulator core
// depends on wsa_pkg; bound to weighted_score_accumulator_core below
`default_nettype none

module wsa_checker
  import wsa_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [CMD_W-1:0] req_command,
  input logic             res_valid,
  input logic             res_ready,
  input logic [SUM_W-1:0] res_sum,
  input logic             res_sat
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sum) && $stable(res_sat))
    else $error("result changed while stalled");

  // clearing pass follows reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !req_ready)
    else $error("item taken during clearing pass after reset");

  // clearing pass follows a clear item
  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_command == CMD_CLEAR |=> !req_ready)
    else $error("item taken during clearing pass after clear");

  // loads do not stall the request channel
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready &&
    (req_command == CMD_LOAD_WEIGHT || req_command == CMD_LOAD_RESIDUAL)
    |=> req_ready)
    else $error("load item stalled the request channel");

endmodule

bind weighted_score_accumulator_core wsa_checker u_wsa_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .req_command (request.command),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_sum     (result.sum_value),
  .res_sat     (result.saturated)
);

`default_nettype wire
